// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the LED section effect engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while the reset is released.
`define LSEE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LSEE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/lsee_pkg.sv -----
// ----------------------------------------------------------------------------
// LED section effect engine package
// Constants, codes, types and helper functions shared by the engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lsee_pkg;

  localparam int SECTIONS         = 4;
  localparam int SEC_N            = 4;
  localparam int SEC_W            = 2;
  localparam int MAX_SECTION_LEDS = 64;
  localparam int STRIP_LEDS       = 256;

  localparam int DVD_W    = 17;
  localparam int DSR_W    = 16;
  localparam int DIV_CNTW = 5;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_SOLID  = 3'd1;
  localparam logic [2:0] ACT_PULSE  = 3'd2;
  localparam logic [2:0] ACT_STREAK = 3'd3;
  localparam logic [2:0] ACT_STOP   = 3'd4;

  localparam logic [1:0] KIND_FILL    = 2'd0;
  localparam logic [1:0] KIND_REFRESH = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_PULSE  = 2'd1;
  localparam logic [1:0] MODE_STREAK = 2'd2;

  localparam logic [2:0] REG_BRIGHT = 3'd0;
  localparam logic [2:0] REG_MINPER = 3'd1;
  localparam logic [2:0] REG_MAXPER = 3'd2;
  localparam logic [2:0] REG_SIZE0  = 3'd3;
  localparam logic [2:0] REG_SIZE1  = 3'd4;
  localparam logic [2:0] REG_SIZE2  = 3'd5;
  localparam logic [2:0] REG_SIZE3  = 3'd6;

  localparam logic [6:0] CLEARED_NONE = 7'h7F;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] first;
    logic [6:0] count;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       acc;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DSR_W-1:0] rem;
  } div_rsp_t;

  // Exact for every product of two bytes plus a rounding term.
  function automatic logic [7:0] div_by_255(input logic [16:0] x);
    logic [16:0] t;
    t = x + {8'b0, x[16:8]} + 17'd1;
    return t[15:8];
  endfunction

  // Exact for every product of a 9-bit value and a byte.
  function automatic logic [7:0] div_by_511(input logic [16:0] x);
    logic [16:0] t;
    t = x + {9'b0, x[16:9]} + 17'd1;
    return t[16:9];
  endfunction

  function automatic res_t make_fill(input logic [8:0] first, input logic [6:0] cnt,
                                     input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b);
    res_t       res;
    logic [8:0] room;
    res.kind  = KIND_FILL;
    res.first = first[7:0];
    res.red   = r;
    res.green = g;
    res.blue  = b;
    res.acc   = 1'b0;
    res.count = cnt;
    room      = 9'(STRIP_LEDS) - first;
    if ({1'b0, first} >= 10'(STRIP_LEDS)) begin
      res.count = '0;
    end else if ({2'b0, cnt} > room) begin
      res.count = room[6:0];
    end
    return res;
  endfunction

  function automatic res_t make_plain(input logic [1:0] kind, input logic acc);
    res_t res;
    res       = '0;
    res.kind  = kind;
    res.acc   = acc;
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lsee_div.sv -----
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces quotient and remainder one bit per cycle for the engine sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lsee_div (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  lsee_pkg::div_req_t  req_i,
  output lsee_pkg::div_rsp_t  rsp_o,
  output logic                busy_o
);
  import lsee_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DIV_CNTW-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]    dvd_q, dvd_d;
  logic [DSR_W-1:0]    dsr_q, dsr_d;
  logic [DSR_W-1:0]    rem_q, rem_d;
  logic [DSR_W:0]      rem_sh;
  logic [DSR_W:0]      rem_sub;
  logic                ge;

  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNTW'(DVD_W - 1);
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      rem_d = ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;
  assign busy_o     = busy_q;

`include "assert_macros.svh"

  `LSEE_ASSERT(a_div_start_idle, req_i.start |-> !busy_q, "divider started while busy")
  `LSEE_ASSERT(a_div_done_after_busy, done_q |-> $past(busy_q), "divider done without work")

endmodule

`default_nettype wire

// ----- hw/rtl/led_section_effect_engine_core.sv -----
// ----------------------------------------------------------------------------
// LED section effect engine core
// Runs solid, pulse and streak effects on strip sections and emits fills,
// refreshes and command status results through a small sequencer.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Content
// in        request    in_valid_i/in_stall_o    action, section, color, period
// out       result     out_valid_o/out_stall_i  kind, range, color, accepted, last
// cfg       write      cfg_we_i                 register index and data
//
// One request is handled at a time; in_stall_o is high until its last result
// has been handed to the output register. A streak step needs four divisions in
// the shared divider and a pulse command one, while scaling by 255 works on one
// color component at a time. Results wait in one pending and one output register
// while out_stall_i is high. Reset is asynchronous and clears all effects.
`default_nettype none

module led_section_effect_engine_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  action_i,
  input  wire  [2:0]  section_i,
  input  wire  [7:0]  red_i,
  input  wire  [7:0]  green_i,
  input  wire  [7:0]  blue_i,
  input  wire  [15:0] period_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  first_led_o,
  output logic [6:0]  led_count_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        accepted_o,
  output logic        last_o,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [15:0] cfg_data_i
);
  import lsee_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_INCW  = 5'd1;
  localparam logic [4:0] S_STAT  = 5'd2;
  localparam logic [4:0] S_SBLK  = 5'd3;
  localparam logic [4:0] S_SC1   = 5'd4;
  localparam logic [4:0] S_SC2   = 5'd6;
  localparam logic [4:0] S_SEMIT = 5'd8;
  localparam logic [4:0] S_SREF  = 5'd9;
  localparam logic [4:0] S_PEMIT = 5'd10;
  localparam logic [4:0] S_TSCAN = 5'd11;
  localparam logic [4:0] S_STRK  = 5'd13;
  localparam logic [4:0] S_SDIV  = 5'd14;
  localparam logic [4:0] S_SDW   = 5'd15;
  localparam logic [4:0] S_SACT  = 5'd16;
  localparam logic [4:0] S_NEXT  = 5'd17;
  localparam logic [4:0] S_REFR  = 5'd18;
  localparam logic [4:0] S_FIN   = 5'd19;

  logic [4:0]  state_q, state_d;

  logic [7:0]  bright_q, bright_d;
  logic [15:0] minper_q, minper_d;
  logic [15:0] maxper_q, maxper_d;
  logic [6:0]  size_q [SEC_N];
  logic [6:0]  size_d [SEC_N];

  logic [1:0]  mode_q  [SEC_N];
  logic [1:0]  mode_d  [SEC_N];
  logic [15:0] per_q   [SEC_N];
  logic [15:0] per_d   [SEC_N];
  logic [31:0] lut_q   [SEC_N];
  logic [31:0] lut_d   [SEC_N];
  logic [23:0] color_q [SEC_N];
  logic [23:0] color_d [SEC_N];
  logic [9:0]  phase_q [SEC_N];
  logic [9:0]  phase_d [SEC_N];
  logic [4:0]  inc_q   [SEC_N];
  logic [4:0]  inc_d   [SEC_N];
  logic [5:0]  pos_q   [SEC_N];
  logic [5:0]  pos_d   [SEC_N];
  logic [6:0]  clr_q   [SEC_N];
  logic [6:0]  clr_d   [SEC_N];
  logic [31:0] time_q, time_d;
  logic [31:0] lrt_q, lrt_d;

  logic [SEC_W-1:0] cs_q, cs_d;
  logic [SEC_W-1:0] idx_q, idx_d;
  logic [23:0] col_q, col_d;
  logic        ok_q, ok_d;
  logic        use_br_q, use_br_d;
  logic [1:0]  ci_q, ci_d;
  logic [1:0]  k_q, k_d;
  logic [7:0]  tmp_q, tmp_d;
  logic [7:0]  br_q, br_d;
  logic [7:0]  sc_q [3];
  logic [7:0]  sc_d [3];
  logic [5:0]  mod_q, mod_d;
  logic        stepped_q, stepped_d;

  res_t        pres_q, pres_d;
  logic        pend_q, pend_d;
  res_t        out_q, out_d;
  logic        out_last_q, out_last_d;
  logic        out_valid_q, out_valid_d;

  logic [6:0]  sz [SEC_N];
  logic [8:0]  st [SEC_N];
  logic        can_push;
  logic        emit_ok;
  logic        emit_en;
  res_t        emit_res;
  logic        accept;
  logic        per_ok;
  logic [7:0]  cbyte;
  logic [9:0]  ph_nx;
  logic [8:0]  tri_v;
  logic [7:0]  c200_r, c200_g, c200_b;
  logic [15:0] prod_r, prod_g, prod_b;
  logic [16:0] q_clamp;
  logic [15:0] mul_br;
  logic [15:0] mul_gb;
  logic [16:0] mul_tri;

  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic        div_busy;

  lsee_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp),
    .busy_o (div_busy)
  );

  always_comb begin
    for (int i = 0; i < SEC_N; i++) begin
      if (size_q[i] == '0) begin
        sz[i] = 7'd1;
      end else if (size_q[i] > 7'(MAX_SECTION_LEDS)) begin
        sz[i] = 7'(MAX_SECTION_LEDS);
      end else begin
        sz[i] = size_q[i];
      end
    end
    st[0] = '0;
    for (int i = 1; i < SEC_N; i++) begin
      st[i] = st[i-1] + {2'b0, sz[i-1]};
    end
  end

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign can_push = !out_valid_q || !out_stall_i;
  assign emit_ok  = !pend_q || can_push;
  assign per_ok   = (period_i != '0) && (period_i >= minper_q) && (period_i <= maxper_q);

  always_comb begin
    case (ci_q)
      2'd0:    cbyte = col_q[23:16];
      2'd1:    cbyte = col_q[15:8];
      default: cbyte = col_q[7:0];
    endcase
  end

  assign ph_nx   = phase_q[idx_q] + {5'b0, inc_q[idx_q]};
  assign tri_v   = ph_nx[9] ? (9'd511 - ph_nx[8:0]) : ph_nx[8:0];
  assign mul_tri = tri_v * 8'd255;
  assign mul_br  = cbyte * br_q;
  assign mul_gb  = (use_br_q ? tmp_q : cbyte) * bright_q;
  assign prod_r  = color_q[cs_q][23:16] * 8'd200;
  assign prod_g  = color_q[cs_q][15:8] * 8'd200;
  assign prod_b  = color_q[cs_q][7:0] * 8'd200;
  assign c200_r  = prod_r[15:8];
  assign c200_g  = prod_g[15:8];
  assign c200_b  = prod_b[15:8];
  assign q_clamp = div_rsp.quot;

  always_comb begin
    state_d   = state_q;
    bright_d  = bright_q;
    minper_d  = minper_q;
    maxper_d  = maxper_q;
    size_d    = size_q;
    mode_d    = mode_q;
    per_d     = per_q;
    lut_d     = lut_q;
    color_d   = color_q;
    phase_d   = phase_q;
    inc_d     = inc_q;
    pos_d     = pos_q;
    clr_d     = clr_q;
    time_d    = time_q;
    lrt_d     = lrt_q;
    cs_d      = cs_q;
    idx_d     = idx_q;
    col_d     = col_q;
    ok_d      = ok_q;
    use_br_d  = use_br_q;
    ci_d      = ci_q;
    k_d       = k_q;
    tmp_d     = tmp_q;
    br_d      = br_q;
    sc_d      = sc_q;
    mod_d     = mod_q;
    stepped_d = stepped_q;
    pres_d    = pres_q;
    pend_d    = pend_q;
    out_d     = out_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    emit_en   = 1'b0;
    emit_res  = make_plain(KIND_STATUS, 1'b0);
    div_req   = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BRIGHT: bright_d  = cfg_data_i[7:0];
        REG_MINPER: minper_d  = cfg_data_i;
        REG_MAXPER: maxper_d  = cfg_data_i;
        REG_SIZE0:  size_d[0] = cfg_data_i[6:0];
        REG_SIZE1:  size_d[1] = cfg_data_i[6:0];
        REG_SIZE2:  size_d[2] = cfg_data_i[6:0];
        REG_SIZE3:  size_d[3] = cfg_data_i[6:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cs_d = section_i[SEC_W-1:0];
          case (action_i)
            ACT_TICK: begin
              time_d    = time_q + 32'd1;
              idx_d     = '0;
              stepped_d = 1'b0;
              state_d   = S_TSCAN;
            end
            ACT_SOLID, ACT_PULSE, ACT_STREAK, ACT_STOP: begin
              ok_d    = 1'b0;
              state_d = S_STAT;
              if (section_i < 3'(SECTIONS)) begin
                if (action_i == ACT_SOLID) begin
                  ok_d  = 1'b1;
                  mode_d[section_i[SEC_W-1:0]] = MODE_NONE;
                  clr_d[section_i[SEC_W-1:0]]  = CLEARED_NONE;
                  col_d    = {red_i, green_i, blue_i};
                  use_br_d = 1'b0;
                  ci_d     = '0;
                  state_d  = S_SC2;
                end else if (action_i == ACT_STOP) begin
                  ok_d  = 1'b1;
                  mode_d[section_i[SEC_W-1:0]] = MODE_NONE;
                  clr_d[section_i[SEC_W-1:0]]  = CLEARED_NONE;
                  state_d = S_SBLK;
                end else if (per_ok) begin
                  per_d[section_i[SEC_W-1:0]]   = period_i;
                  color_d[section_i[SEC_W-1:0]] = {red_i, green_i, blue_i};
                  if (action_i == ACT_PULSE) begin
                    mode_d[section_i[SEC_W-1:0]]  = MODE_PULSE;
                    phase_d[section_i[SEC_W-1:0]] = '0;
                    div_req.start    = 1'b1;
                    div_req.dividend = 17'd10240;
                    div_req.divisor  = period_i;
                    state_d = S_INCW;
                  end else begin
                    ok_d = 1'b1;
                    mode_d[section_i[SEC_W-1:0]] = MODE_STREAK;
                    pos_d[section_i[SEC_W-1:0]]  = '0;
                    clr_d[section_i[SEC_W-1:0]]  = CLEARED_NONE;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_INCW: begin
        if (div_rsp.done) begin
          if (q_clamp < 17'd2) begin
            inc_d[cs_q] = 5'd2;
          end else if (q_clamp > 17'd20) begin
            inc_d[cs_q] = 5'd20;
          end else begin
            inc_d[cs_q] = q_clamp[4:0];
          end
          ok_d    = 1'b1;
          state_d = S_STAT;
        end
      end

      S_STAT: begin
        if (emit_ok) begin
          emit_en  = 1'b1;
          emit_res = make_plain(KIND_STATUS, ok_q);
          state_d  = S_FIN;
        end
      end

      S_SBLK: begin
        if (emit_ok) begin
          emit_en  = 1'b1;
          emit_res = make_fill(st[cs_q], sz[cs_q], 8'd0, 8'd0, 8'd0);
          state_d  = S_STAT;
        end
      end

      S_SC1: begin
        tmp_d   = div_by_255({1'b0, mul_br});
        state_d = S_SC2;
      end

      S_SC2: begin
        sc_d[ci_q] = div_by_255({1'b0, mul_gb} + 17'd127);
        if (ci_q == 2'd2) begin
          state_d = use_br_q ? S_PEMIT : S_SEMIT;
        end else begin
          ci_d    = ci_q + 2'd1;
          state_d = use_br_q ? S_SC1 : S_SC2;
        end
      end

      S_SEMIT: begin
        if (emit_ok) begin
          emit_en  = 1'b1;
          emit_res = make_fill(st[cs_q], sz[cs_q], sc_q[0], sc_q[1], sc_q[2]);
          state_d  = S_SREF;
        end
      end

      S_SREF: begin
        if (emit_ok) begin
          emit_en  = 1'b1;
          emit_res = make_plain(KIND_REFRESH, 1'b0);
          state_d  = S_STAT;
        end
      end

      S_PEMIT: begin
        if (emit_ok) begin
          emit_en     = 1'b1;
          emit_res    = make_fill(st[cs_q], sz[cs_q], sc_q[0], sc_q[1], sc_q[2]);
          lut_d[cs_q] = time_q;
          stepped_d   = 1'b1;
          state_d     = S_NEXT;
        end
      end

      S_TSCAN: begin
        cs_d    = idx_q;
        state_d = S_NEXT;
        if ((mode_q[idx_q] != MODE_NONE) &&
            ((time_q - lut_q[idx_q]) >= {16'b0, per_q[idx_q]})) begin
          if (mode_q[idx_q] == MODE_PULSE) begin
            phase_d[idx_q] = ph_nx;
            br_d     = div_by_511(mul_tri);
            col_d    = color_q[idx_q];
            use_br_d = 1'b1;
            ci_d     = '0;
            state_d  = S_SC1;
          end else if (mode_q[idx_q] == MODE_STREAK) begin
            state_d = S_STRK;
          end
        end
      end

      S_STRK: begin
        k_d = '0;
        if ((clr_q[cs_q] != CLEARED_NONE) && (clr_q[cs_q] != {1'b0, pos_q[cs_q]}) &&
            (clr_q[cs_q] < sz[cs_q])) begin
          if (emit_ok) begin
            emit_en  = 1'b1;
            emit_res = make_fill(st[cs_q] + {2'b0, clr_q[cs_q]}, 7'd1, 8'd0, 8'd0, 8'd0);
            state_d  = S_SDIV;
          end
        end else begin
          state_d = S_SDIV;
        end
      end

      S_SDIV: begin
        div_req.start   = 1'b1;
        div_req.divisor = {9'b0, sz[cs_q]};
        if (k_q == 2'd3) begin
          div_req.dividend = {11'b0, pos_q[cs_q]} + 17'd1;
        end else begin
          div_req.dividend = {11'b0, pos_q[cs_q]} + {9'b0, sz[cs_q], 1'b0} - {15'b0, k_q};
        end
        state_d = S_SDW;
      end

      S_SDW: begin
        if (div_rsp.done) begin
          mod_d   = div_rsp.rem[5:0];
          state_d = S_SACT;
        end
      end

      S_SACT: begin
        case (k_q)
          2'd0, 2'd1: begin
            if (emit_ok) begin
              emit_en  = 1'b1;
              emit_res = make_fill(st[cs_q] + {3'b0, mod_q}, 7'd1, c200_r, c200_g, c200_b);
              k_d      = k_q + 2'd1;
              state_d  = S_SDIV;
            end
          end
          2'd2: begin
            clr_d[cs_q] = {1'b0, mod_q};
            k_d         = 2'd3;
            state_d     = S_SDIV;
          end
          default: begin
            pos_d[cs_q] = mod_q;
            lut_d[cs_q] = time_q;
            stepped_d   = 1'b1;
            state_d     = S_NEXT;
          end
        endcase
      end

      S_NEXT: begin
        if (idx_q == SEC_W'(SECTIONS - 1)) begin
          state_d = S_REFR;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_TSCAN;
        end
      end

      S_REFR: begin
        if (stepped_q && ((time_q - lrt_q) >= 32'd16)) begin
          if (emit_ok) begin
            emit_en  = 1'b1;
            emit_res = make_plain(KIND_REFRESH, 1'b0);
            lrt_d    = time_q;
            state_d  = S_FIN;
          end
        end else begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (!pend_q) begin
          state_d = S_IDLE;
        end else if (can_push) begin
          out_d       = pres_q;
          out_last_d  = 1'b1;
          out_valid_d = 1'b1;
          pend_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (emit_en) begin
      if (pend_q) begin
        out_d       = pres_q;
        out_last_d  = 1'b0;
        out_valid_d = 1'b1;
      end
      pres_d = emit_res;
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bright_q    <= 8'd128;
      minper_q    <= 16'd10;
      maxper_q    <= 16'd10000;
      time_q      <= '0;
      lrt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      stepped_q   <= 1'b0;
      for (int i = 0; i < SEC_N; i++) begin
        size_q[i]  <= 7'd16;
        mode_q[i]  <= MODE_NONE;
        per_q[i]   <= '0;
        lut_q[i]   <= '0;
        color_q[i] <= '0;
        phase_q[i] <= '0;
        inc_q[i]   <= '0;
        pos_q[i]   <= '0;
        clr_q[i]   <= CLEARED_NONE;
      end
    end else begin
      state_q     <= state_d;
      bright_q    <= bright_d;
      minper_q    <= minper_d;
      maxper_q    <= maxper_d;
      time_q      <= time_d;
      lrt_q       <= lrt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      stepped_q   <= stepped_d;
      size_q      <= size_d;
      mode_q      <= mode_d;
      per_q       <= per_d;
      lut_q       <= lut_d;
      color_q     <= color_d;
      phase_q     <= phase_d;
      inc_q       <= inc_d;
      pos_q       <= pos_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cs_q       <= cs_d;
    idx_q      <= idx_d;
    col_q      <= col_d;
    ok_q       <= ok_d;
    use_br_q   <= use_br_d;
    ci_q       <= ci_d;
    k_q        <= k_d;
    tmp_q      <= tmp_d;
    br_q       <= br_d;
    sc_q       <= sc_d;
    mod_q      <= mod_d;
    pres_q     <= pres_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign kind_o      = out_q.kind;
  assign first_led_o = out_q.first;
  assign led_count_o = out_q.count;
  assign out_red_o   = out_q.red;
  assign out_green_o = out_q.green;
  assign out_blue_o  = out_q.blue;
  assign accepted_o  = out_q.acc;
  assign last_o      = out_last_q;

`include "assert_macros.svh"

  `LSEE_ASSERT(a_idle_no_pending, (state_q == S_IDLE) |-> !pend_q, "pending result left in idle")
  `LSEE_ASSERT(a_emit_has_room, (emit_en && pend_q) |-> can_push, "pending result overwritten")
  `LSEE_ASSERT(a_div_unused_start, div_req.start |-> !div_busy, "divider request while busy")

endmodule

`default_nettype wire
